// ===== design/rqro_pkg.sv =====
// ----------------------------------------------------------------------------
// rqro_pkg: shared types and constants for the ring queue
// Field widths of the item channels, command codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rqro_pkg;

	localparam int CMD_W = 3;
	localparam int DIO_W = 8;
	localparam int OFS_W = 6;
	localparam int CNT_W = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ    = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_DUMP   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TAKE,
		ST_SHIFT,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== design/rqro_req_if.sv =====
// ----------------------------------------------------------------------------
// rqro_req_if: command channel of the ring queue
// Valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rqro_req_if;
	logic                       valid;
	logic                       ready;
	logic [rqro_pkg::CMD_W-1:0] cmd;
	logic [rqro_pkg::DIO_W-1:0] wr_data;
	logic [rqro_pkg::OFS_W-1:0] offset;
	logic [rqro_pkg::CNT_W-1:0] limit;

	modport source (output valid, output cmd, output wr_data, output offset, output limit,
		input ready);
	modport sink (input valid, input cmd, input wr_data, input offset, input limit,
		output ready);
endinterface

`default_nettype wire

// ===== design/rqro_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rqro_rsp_if: result channel of the ring queue
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rqro_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       ok;
	logic [rqro_pkg::DIO_W-1:0] rd_data;
	logic [rqro_pkg::CNT_W-1:0] count;
	logic                       is_empty;
	logic                       is_full;
	logic                       last;

	modport source (output valid, output ok, output rd_data, output count, output is_empty,
		output is_full, output last, input ready);
	modport sink (input valid, input ok, input rd_data, input count, input is_empty,
		input is_full, input last, output ready);
endinterface

`default_nettype wire

// ===== design/ring_queue_with_remove_at_offset_top.sv =====
// ----------------------------------------------------------------------------
// ring_queue_with_remove_at_offset_top: ring queue with remove at offset
// DEPTH-slot ring holding up to DEPTH-1 items; enqueue, remove at offset,
// peek at offset, dump from head, clear. One memory, one sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | cmd, wr_data, offset, limit
//  rsp     | out | valid/ready | ok, rd_data, count, is_empty, is_full, last
//
//  Remove moves the items between head and the removed slot one slot per
//  cycle. The slot memory has one write port and one registered read port.
//  req.ready is high only in idle; one result register feeds rsp, and the
//  sequencer waits while it is full. Reset clears head, tail and control.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_queue_with_remove_at_offset_top #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	rqro_req_if.sink       req,
	rqro_rsp_if.source     rsp
);
	import rqro_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
	localparam logic [PW:0]   DEPTH_X = (PW + 1)'(DEPTH);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_MAX) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PTR_MAX : p - 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[PW-1:0];
	endfunction

	state_t state_q, state_d;

	logic [PW-1:0]         head_q, head_d, tail_q, tail_d;
	logic [PW-1:0]         pos_q, pos_d, src_q, src_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [DATA_WIDTH-1:0] data_q, data_d;
	logic                  ok_q, ok_d, last_q, last_d;

	logic [CMD_W-1:0]      cmd_q;
	logic [DATA_WIDTH-1:0] wdat_q;
	logic [OFS_W-1:0]      off_q;
	logic [CNT_W-1:0]      lim_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] mem_rdat_q;
	logic                  mem_we, mem_re;
	logic [PW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata;

	logic                  out_valid_q, out_valid_d;
	logic                  out_ok_q, out_empty_q, out_full_q, out_last_q;
	logic [DIO_W-1:0]      out_rd_q;
	logic [CNT_W-1:0]      out_cnt_q;
	logic                  in_ld, out_ld, emit_go;

	logic [PW-1:0]               occ;
	logic [CNT_W+PW-1:0]         occ_ext;
	logic [CNT_W-1:0]            occ_cnt;
	logic                        q_full, off_ok;
	logic [CNT_W-1:0]            dump_n;
	logic [PW-1:0]               pos_off;
	logic [DATA_WIDTH+DIO_W-1:0] wr_ext;
	logic [DATA_WIDTH+DIO_W-1:0] rd_ext;
	logic                        dump_more;

	always_comb begin
		if (tail_q >= head_q) begin
			occ = tail_q - head_q;
		end else begin
			occ = PW'({1'b0, tail_q} + DEPTH_X - {1'b0, head_q});
		end
	end

	assign occ_ext   = {{CNT_W{1'b0}}, occ};
	assign occ_cnt   = occ_ext[CNT_W-1:0];
	assign q_full    = (ptr_inc(tail_q) == head_q);
	assign off_ok    = (off_q < occ_cnt);
	assign dump_n    = (occ_cnt < lim_q) ? occ_cnt : lim_q;
	assign pos_off   = ptr_add(head_q, off_q[PW-1:0]);
	assign wr_ext    = {{DATA_WIDTH{1'b0}}, req.wr_data};
	assign rd_ext    = {{DIO_W{1'b0}}, data_q};
	assign emit_go   = !out_valid_q || rsp.ready;
	assign dump_more = (cmd_q == CMD_DUMP) && ok_q && !last_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_REMOVE, CMD_PEEK: state_d = off_ok ? ST_TAKE : ST_EMIT;
					CMD_DUMP:             state_d = (dump_n != '0) ? ST_TAKE : ST_EMIT;
					default:              state_d = ST_EMIT;
				endcase
			end
			ST_TAKE: begin
				if ((cmd_q == CMD_REMOVE) && (cnt_q != '0)) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SHIFT: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = dump_more ? ST_TAKE : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		pos_d       = pos_q;
		src_d       = src_q;
		cnt_d       = cnt_q;
		data_d      = data_q;
		ok_d        = ok_q;
		last_d      = last_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_waddr   = tail_q;
		mem_wdata   = wdat_q;
		mem_raddr   = pos_q;
		in_ld       = 1'b0;
		out_ld      = 1'b0;
		out_valid_d = out_valid_q && !rsp.ready;
		case (state_q)
			ST_IDLE: begin
				in_ld = req.valid;
			end
			ST_EXEC: begin
				last_d = 1'b1;
				data_d = '0;
				ok_d   = 1'b0;
				case (cmd_q)
					CMD_ENQ: begin
						if (!q_full) begin
							mem_we = 1'b1;
							tail_d = ptr_inc(tail_q);
							ok_d   = 1'b1;
						end
					end
					CMD_REMOVE, CMD_PEEK: begin
						if (off_ok) begin
							mem_re    = 1'b1;
							mem_raddr = pos_off;
							pos_d     = pos_off;
							src_d     = ptr_dec(pos_off);
							cnt_d     = off_q;
							ok_d      = 1'b1;
						end
					end
					CMD_DUMP: begin
						if (dump_n != '0) begin
							mem_re    = 1'b1;
							mem_raddr = head_q;
							pos_d     = head_q;
							cnt_d     = dump_n;
							ok_d      = 1'b1;
						end
					end
					CMD_CLEAR: begin
						head_d = '0;
						tail_d = '0;
						ok_d   = 1'b1;
					end
					default: begin
						ok_d = 1'b0;
					end
				endcase
			end
			ST_TAKE: begin
				data_d = mem_rdat_q;
				if (cmd_q == CMD_REMOVE) begin
					if (cnt_q == '0) begin
						head_d = ptr_inc(head_q);
					end else begin
						mem_re    = 1'b1;
						mem_raddr = src_q;
					end
				end
				if (cmd_q == CMD_DUMP) begin
					last_d = (cnt_q == CNT_W'(1));
				end
			end
			ST_SHIFT: begin
				// move one item toward the removed slot, fetch the next one
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = mem_rdat_q;
				mem_re    = 1'b1;
				mem_raddr = ptr_dec(src_q);
				pos_d     = src_q;
				src_d     = ptr_dec(src_q);
				cnt_d     = cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					head_d = ptr_inc(head_q);
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_ld      = 1'b1;
					out_valid_d = 1'b1;
					if (dump_more) begin
						pos_d     = ptr_inc(pos_q);
						cnt_d     = cnt_q - 1'b1;
						mem_re    = 1'b1;
						mem_raddr = ptr_inc(pos_q);
					end
				end
			end
			default: begin
				in_ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			ok_q        <= 1'b0;
			last_q      <= 1'b0;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			cnt_q       <= cnt_d;
			ok_q        <= ok_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
			if (in_ld) begin
				cmd_q <= req.cmd;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		src_q  <= src_d;
		data_q <= data_d;
		if (in_ld) begin
			wdat_q <= wr_ext[DATA_WIDTH-1:0];
			off_q  <= req.offset;
			lim_q  <= req.limit;
		end
		if (out_ld) begin
			out_ok_q    <= ok_q;
			out_rd_q    <= rd_ext[DIO_W-1:0];
			out_cnt_q   <= occ_cnt;
			out_empty_q <= (occ == '0);
			out_full_q  <= q_full;
			out_last_q  <= last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdat_q <= mem[mem_raddr];
		end
	end

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.ok       = out_ok_q;
	assign rsp.rd_data  = out_rd_q;
	assign rsp.count    = out_cnt_q;
	assign rsp.is_empty = out_empty_q;
	assign rsp.is_full  = out_full_q;
	assign rsp.last     = out_last_q;

endmodule

`default_nettype wire

// ===== design/rqro_checker.sv =====
// ----------------------------------------------------------------------------
// rqro_checker: port-level checks for the ring queue
// Watches both item channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rqro_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic                       rsp_ok,
	input wire logic [rqro_pkg::DIO_W-1:0] rsp_rd_data,
	input wire logic [rqro_pkg::CNT_W-1:0] rsp_count,
	input wire logic                       rsp_is_empty,
	input wire logic                       rsp_is_full,
	input wire logic                       rsp_last
);
	import rqro_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_rd_data)
			&& $stable(rsp_count) && $stable(rsp_last))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready high right after accepting an item");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
		else $error("empty flag disagrees with count");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_is_empty && rsp_is_full))
		else $error("empty and full together");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> (rsp_rd_data == '0) && rsp_last)
		else $error("refused item carries data or is not last");

endmodule

bind ring_queue_with_remove_at_offset_top rqro_checker u_rqro_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_ok      (rsp.ok),
	.rsp_rd_data (rsp.rd_data),
	.rsp_count   (rsp.count),
	.rsp_is_empty(rsp.is_empty),
	.rsp_is_full (rsp.is_full),
	.rsp_last    (rsp.last)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ring queue with remove at offset
// Drives command items over the req channel with random gaps, predicts every
// result from a list model of the held items, and compares each rsp item
// field by field against the oldest prediction while rsp.ready stalls at
// random. Covers empty and full edges, bad offsets, long shifts, long dumps,
// clear and unknown command codes.
// ----------------------------------------------------------------------------

module tb;
	import rqro_pkg::*;

	localparam int DEPTH       = 64;
	localparam int DATA_WIDTH  = 8;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int TAIL_CYCLES = 200;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic             ok;
		logic [DIO_W-1:0] rd_data;
		logic [CNT_W-1:0] count;
		logic             is_empty;
		logic             is_full;
		logic             last;
	} rsp_item_t;

	logic clk;
	logic arst_n;

	rqro_req_if req_ch ();
	rqro_rsp_if rsp_ch ();

	ring_queue_with_remove_at_offset_top #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [DIO_W-1:0] held_items[$];
	rsp_item_t        pending_rsp[$];
	int               mismatch_cnt = 0;
	bit               no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void push_rsp(logic ok, logic [DIO_W-1:0] d, logic last);
		rsp_item_t e;
		e.ok       = ok;
		e.rd_data  = d;
		e.count    = CNT_W'(held_items.size());
		e.is_empty = (held_items.size() == 0);
		e.is_full  = (held_items.size() == DEPTH - 1);
		e.last     = last;
		pending_rsp.push_back(e);
	endfunction

	// Queue behavior on one accepted command; results go to pending_rsp.
	function automatic void model_queue_op(logic [CMD_W-1:0] cmd, logic [DIO_W-1:0] wd,
		logic [OFS_W-1:0] ofs, logic [CNT_W-1:0] lim);
		int               n;
		int               run;
		logic [DIO_W-1:0] d;
		n = held_items.size();
		case (cmd)
			CMD_ENQ: begin
				if (n == DEPTH - 1) begin
					push_rsp(1'b0, '0, 1'b1);
				end else begin
					held_items.push_back(wd);
					push_rsp(1'b1, '0, 1'b1);
				end
			end
			CMD_REMOVE: begin
				if (int'(ofs) >= n) begin
					push_rsp(1'b0, '0, 1'b1);
				end else begin
					d = held_items[ofs];
					held_items.delete(ofs);
					push_rsp(1'b1, d, 1'b1);
				end
			end
			CMD_PEEK: begin
				if (int'(ofs) >= n) push_rsp(1'b0, '0, 1'b1);
				else push_rsp(1'b1, held_items[ofs], 1'b1);
			end
			CMD_DUMP: begin
				run = (n < int'(lim)) ? n : int'(lim);
				if (run == 0) begin
					push_rsp(1'b0, '0, 1'b1);
				end else begin
					for (int i = 0; i < run; i++)
						push_rsp(1'b1, held_items[i], i == run - 1);
				end
			end
			CMD_CLEAR: begin
				held_items.delete();
				push_rsp(1'b1, '0, 1'b1);
			end
			default: begin
				push_rsp(1'b0, '0, 1'b1);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, int exp_v, int got_v);
		if (mismatch_cnt < MAX_REPORTS)
			$display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
		mismatch_cnt++;
	endtask

	task automatic send_item(logic [CMD_W-1:0] cmd, logic [DIO_W-1:0] wd,
		logic [OFS_W-1:0] ofs, logic [CNT_W-1:0] lim);
		int g;
		g = pick_gap();
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.cmd     <= cmd;
		req_ch.wr_data <= wd;
		req_ch.offset  <= ofs;
		req_ch.limit   <= lim;
		do @(posedge clk); while (!req_ch.ready);
		model_queue_op(cmd, wd, ofs, lim);
	endtask

	// Result sink with random stalls.
	initial begin
		int g;
		forever begin
			g = pick_gap();
			if (g > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		rsp_item_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result", 0, 1);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_ch.ok !== e.ok) report_mismatch("ok", e.ok, rsp_ch.ok);
				if (rsp_ch.rd_data !== e.rd_data)
					report_mismatch("rd_data", e.rd_data, rsp_ch.rd_data);
				if (rsp_ch.count !== e.count) report_mismatch("count", e.count, rsp_ch.count);
				if (rsp_ch.is_empty !== e.is_empty)
					report_mismatch("is_empty", e.is_empty, rsp_ch.is_empty);
				if (rsp_ch.is_full !== e.is_full)
					report_mismatch("is_full", e.is_full, rsp_ch.is_full);
				if (rsp_ch.last !== e.last) report_mismatch("last", e.last, rsp_ch.last);
			end
		end
	end

	initial begin
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic test_directed();
		send_item(CMD_CLEAR, 8'h00, 6'd0, 6'd0);
		send_item(CMD_PEEK, 8'h00, 6'd0, 6'd0);
		send_item(CMD_REMOVE, 8'h00, 6'd0, 6'd0);
		send_item(CMD_DUMP, 8'h00, 6'd0, 6'd5);
		send_item(CMD_ENQ, 8'h00, 6'd0, 6'd0);
		send_item(CMD_ENQ, 8'hFF, 6'd63, 6'd63);
		send_item(CMD_ENQ, 8'hA5, 6'd0, 6'd0);
		send_item(CMD_ENQ, 8'h5A, 6'd0, 6'd0);
		send_item(CMD_PEEK, 8'h00, 6'd0, 6'd0);
		send_item(CMD_PEEK, 8'h00, 6'd3, 6'd0);
		send_item(CMD_PEEK, 8'h00, 6'd4, 6'd0);
		send_item(CMD_REMOVE, 8'h00, 6'd63, 6'd0);
		send_item(CMD_DUMP, 8'h00, 6'd0, 6'd0);
		send_item(CMD_DUMP, 8'h00, 6'd0, 6'd63);
		send_item(CMD_REMOVE, 8'h00, 6'd1, 6'd0);
		send_item(CMD_REMOVE, 8'h00, 6'd2, 6'd0);
		send_item(CMD_REMOVE, 8'h00, 6'd0, 6'd0);
		send_item(3'd5, 8'h3C, 6'd0, 6'd1);
		send_item(3'd6, 8'h00, 6'd0, 6'd0);
		send_item(3'd7, 8'hFF, 6'd63, 6'd63);
		send_item(CMD_DUMP, 8'h00, 6'd0, 6'd1);
		send_item(CMD_CLEAR, 8'h00, 6'd0, 6'd0);
	endtask

	task automatic test_fill_and_drain();
		while (held_items.size() < DEPTH - 1)
			send_item(CMD_ENQ, DIO_W'($urandom), 6'd0, 6'd0);
		send_item(CMD_ENQ, DIO_W'($urandom), 6'd0, 6'd0);
		send_item(CMD_PEEK, 8'h00, 6'd62, 6'd0);
		send_item(CMD_PEEK, 8'h00, 6'd63, 6'd0);
		send_item(CMD_DUMP, 8'h00, 6'd0, 6'd63);
		send_item(CMD_REMOVE, 8'h00, 6'd62, 6'd0);
		send_item(CMD_ENQ, DIO_W'($urandom), 6'd0, 6'd0);
		send_item(CMD_REMOVE, 8'h00, 6'd0, 6'd0);
		send_item(CMD_REMOVE, 8'h00, 6'd31, 6'd0);
		send_item(CMD_DUMP, 8'h00, 6'd0, 6'd40);
	endtask

	task automatic test_random_ops(int items);
		int               r;
		int               n;
		logic [CMD_W-1:0] cmd;
		logic [OFS_W-1:0] ofs;
		logic [CNT_W-1:0] lim;
		for (int k = 0; k < items; k++) begin
			no_idle = (k >= items / 3) && (k < items / 3 + 30);
			n = held_items.size();
			r = $urandom_range(0, 99);
			if (r < ((n < 8) ? 55 : 35)) cmd = CMD_ENQ;
			else if (r < 62) cmd = CMD_REMOVE;
			else if (r < 80) cmd = CMD_PEEK;
			else if (r < 91) cmd = CMD_DUMP;
			else if (r < 94) cmd = CMD_CLEAR;
			else cmd = CMD_W'($urandom_range(5, 7));
			if (n > 0 && $urandom_range(0, 99) < 85) ofs = OFS_W'($urandom_range(0, n - 1));
			else ofs = OFS_W'($urandom_range(0, 63));
			if ($urandom_range(0, 9) < 8) lim = CNT_W'($urandom_range(0, 8));
			else lim = CNT_W'($urandom_range(0, 63));
			send_item(cmd, DIO_W'($urandom), ofs, lim);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int tail;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.cmd     <= CMD_ENQ;
		req_ch.wr_data <= '0;
		req_ch.offset  <= '0;
		req_ch.limit   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_random_ops(130);
		req_ch.valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		tail = 0;
		while (tail < TAIL_CYCLES) begin
			@(posedge clk);
			tail++;
		end
		if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
